>>> rtl/core/nfm_pkg.sv
`timescale 1ns / 1ps
// Package for the nearest feature match block: sizes, command and register codes,
// beat and pipeline tag types, and the feature store address helper. No dependencies.

package nfm_pkg;

   localparam int ENTRIES = 64;
   localparam int DIM     = 256;

   // Field widths fixed by the beat formats.
   localparam int SLOT_W = 6;
   localparam int NAME_W = 16;
   localparam int ELEM_W = 16;
   localparam int THR_W  = 40;

   // Derived sizes.
   localparam int ENT_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int DIM_AW    = (DIM > 1) ? $clog2(DIM) : 1;
   localparam int POS_W     = $clog2(DIM + 1);
   localparam int FEAT_DEPTH = ENTRIES * DIM;
   localparam int FEAT_AW   = (FEAT_DEPTH > 1) ? $clog2(FEAT_DEPTH) : 1;
   localparam int SQ_W      = 2 * ELEM_W;
   localparam int ACC_W     = SQ_W + $clog2(DIM);
   localparam int CMP_W     = (ACC_W > THR_W) ? ACC_W : THR_W;

   // Configuration port.
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 64;
   localparam logic CSR_IDX_THRESHOLD = 1'b0;
   localparam logic [THR_W-1:0] THRESHOLD_RESET = {THR_W{1'b1}};

   // Commands carried by an input beat.
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   typedef struct packed {
      logic                     cmd;
      logic [SLOT_W-1:0]        slot;
      logic [NAME_W-1:0]        name_id;
      logic signed [ELEM_W-1:0] element;
      logic                     last;
   } req_type;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] best_slot;
      logic [NAME_W-1:0] best_name_id;
      logic [THR_W-1:0]  best_distance;
   } rsp_type;

   // Tag that travels with each element through the distance pipeline.
   typedef struct packed {
      logic             act;
      logic             last;
      logic             hit;
      logic [ENT_W-1:0] entry;
   } srch_tag_type;

   function automatic logic [FEAT_AW-1:0] feat_addr(input logic [ENT_W-1:0] entry,
                                                    input logic [DIM_AW-1:0] idx);
      feat_addr = FEAT_AW'(entry) * FEAT_AW'(DIM) + FEAT_AW'(idx);
   endfunction

endpackage

>>> rtl/core/nearest_feature_match.sv
`timescale 1ns / 1ps
// Nearest feature match: reference vector store and brute-force squared Euclidean search.
// Depends on nfm_pkg for sizes, codes and the beat types.
//
//  Channel   Direction  Handshake              Payload
//  req       in         req_valid / req_stall  nfm_pkg::req_type (one vector element)
//  rsp       out        rsp_valid / rsp_stall  nfm_pkg::rsp_type (one search result)
//  csr       in/out     APB psel/penable/...   match_threshold at byte address 0
//
// Each element beat is taken while req_stall is low. A vector that ends early then has the rest
// of its row zero-filled with req_stall high. A query ends with a search of all ENTRIES * DIM
// elements through the single subtract, square and accumulate unit, then the pipeline drain and
// the posting of the result. Reset (synchronous, active high) clears the valid bits, the position
// and the handshakes and sets the threshold to all ones; the stores get no clearing pass.
// A stalled result waits while new beats come in.

module nearest_feature_match (
   input  logic                        clock,
   input  logic                        reset,
   // element beats
   input  logic                        req_valid,
   output logic                        req_stall,
   input  nfm_pkg::req_type            req_beat,
   // result beats
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output nfm_pkg::rsp_type            rsp_beat,
   // configuration
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [nfm_pkg::CSR_AW-1:0]  paddr,
   input  logic [nfm_pkg::CSR_DW-1:0]  pwdata,
   output logic [nfm_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready
);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_FILL   = 2'd1;
   localparam logic [1:0] ST_SEARCH = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   // Storage. The feature, query and name stores are plain memories with registered reads.
   logic signed [nfm_pkg::ELEM_W-1:0] feat_mem [nfm_pkg::FEAT_DEPTH];
   logic signed [nfm_pkg::ELEM_W-1:0] qry_mem  [nfm_pkg::DIM];
   logic        [nfm_pkg::NAME_W-1:0] name_mem [nfm_pkg::ENTRIES];

   logic [1:0]                    state_ff, state_in;
   logic [nfm_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic [nfm_pkg::DIM_AW-1:0]    fill_pos_ff, fill_pos_in;
   logic                          fill_query_ff, fill_query_in;
   logic [nfm_pkg::ENT_W-1:0]     fill_entry_ff, fill_entry_in;
   logic [nfm_pkg::ENTRIES-1:0]   entry_valid_ff, entry_valid_in;
   logic [nfm_pkg::THR_W-1:0]     threshold_ff, threshold_in;

   // Search issue counters.
   logic                          issue_ff, issue_in;
   logic [nfm_pkg::DIM_AW-1:0]    s_elem_ff, s_elem_in;
   logic [nfm_pkg::ENT_W-1:0]     s_entry_ff, s_entry_in;
   logic [nfm_pkg::FEAT_AW-1:0]   s_addr_ff, s_addr_in;

   // Distance pipeline.
   nfm_pkg::srch_tag_type             t1_ff, t1_in, t2_ff, t3_ff;
   logic signed [nfm_pkg::ELEM_W-1:0] feat_rd_ff, qry_rd_ff;
   logic [nfm_pkg::NAME_W-1:0]        name_rd_ff, name2_ff, name3_ff;
   logic [nfm_pkg::ELEM_W-1:0]        diff_ff, diff_in;
   logic [nfm_pkg::SQ_W-1:0]          sq_ff, sq_in;
   logic [nfm_pkg::ACC_W-1:0]         acc_ff, acc_in;
   logic [nfm_pkg::THR_W-1:0]         best_ff, best_in;
   logic [nfm_pkg::ENT_W-1:0]         best_entry_ff, best_entry_in;
   logic [nfm_pkg::NAME_W-1:0]        best_name_ff, best_name_in;
   logic                              found_ff, found_in;

   // Output register.
   logic                          rsp_valid_ff, rsp_valid_in;
   nfm_pkg::rsp_type              rsp_beat_ff, rsp_beat_in;

   // Memory write ports.
   logic                              fw_en, qw_en, nw_en;
   logic [nfm_pkg::FEAT_AW-1:0]       fw_addr;
   logic [nfm_pkg::DIM_AW-1:0]        qw_addr;
   logic signed [nfm_pkg::ELEM_W-1:0] fw_data, qw_data;

   // Load path decode.
   logic                          req_acc;
   logic                          is_query;
   logic                          slot_ok;
   logic                          vec_ok;
   logic                          pos_room;
   logic [nfm_pkg::POS_W-1:0]     pos_next;
   logic [nfm_pkg::DIM_AW-1:0]    ld_idx;
   logic [nfm_pkg::ENT_W-1:0]     ld_entry;
   logic                          start_search;
   logic                          pipe_busy;
   logic signed [nfm_pkg::ELEM_W:0] diff_wide;
   logic [nfm_pkg::ACC_W-1:0]     total;
   logic                          csr_wr;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;
   assign pready    = 1'b1;

   // The threshold is the only register; the low address bits are ignored and it is read and written whole.
   assign csr_wr = psel & penable & pwrite & (paddr[3] == nfm_pkg::CSR_IDX_THRESHOLD);
   assign prdata = (paddr[3] == nfm_pkg::CSR_IDX_THRESHOLD)
                 ? nfm_pkg::CSR_DW'(threshold_ff) : '0;
   assign threshold_in = csr_wr ? pwdata[nfm_pkg::THR_W-1:0] : threshold_ff;

   assign is_query = (req_beat.cmd == nfm_pkg::CMD_QUERY);
   assign slot_ok  = (int'(req_beat.slot) < nfm_pkg::ENTRIES);
   assign vec_ok   = is_query | slot_ok;
   assign pos_room = (pos_ff < nfm_pkg::POS_W'(nfm_pkg::DIM));
   assign pos_next = pos_room ? pos_ff + 1'b1 : pos_ff;
   assign ld_idx   = pos_ff[nfm_pkg::DIM_AW-1:0];
   assign ld_entry = nfm_pkg::ENT_W'(req_beat.slot);

   assign pipe_busy = issue_ff | t1_ff.act | t2_ff.act | t3_ff.act;

   // Memory write selection: element beats while idle, zeros during a fill sweep.
   always_comb begin
      fw_en   = 1'b0;
      fw_addr = nfm_pkg::feat_addr(ld_entry, ld_idx);
      fw_data = req_beat.element;
      qw_en   = 1'b0;
      qw_addr = ld_idx;
      qw_data = req_beat.element;
      nw_en   = req_acc & req_beat.last & ~is_query & slot_ok;
      if (req_acc) begin
         fw_en = ~is_query & slot_ok & pos_room;
         qw_en = is_query & pos_room;
      end else if (state_ff == ST_FILL) begin
         fw_en   = ~fill_query_ff;
         fw_addr = nfm_pkg::feat_addr(fill_entry_ff, fill_pos_ff);
         fw_data = '0;
         qw_en   = fill_query_ff;
         qw_addr = fill_pos_ff;
         qw_data = '0;
      end
   end

   // Sequencer: element loading, zero fill and search start/finish.
   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff;
      fill_pos_in    = fill_pos_ff;
      fill_query_in  = fill_query_ff;
      fill_entry_in  = fill_entry_ff;
      entry_valid_in = entry_valid_ff;
      start_search   = 1'b0;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_beat_in    = rsp_beat_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               pos_in = req_beat.last ? '0 : pos_next;
               if (req_beat.last) begin
                  if (~is_query && slot_ok) begin
                     entry_valid_in[ld_entry] = 1'b1;
                  end
                  if (vec_ok && pos_next < nfm_pkg::POS_W'(nfm_pkg::DIM)) begin
                     // A short vector: zero the rest of its row first.
                     state_in      = ST_FILL;
                     fill_pos_in   = pos_next[nfm_pkg::DIM_AW-1:0];
                     fill_query_in = is_query;
                     fill_entry_in = ld_entry;
                  end else if (is_query) begin
                     state_in     = ST_SEARCH;
                     start_search = 1'b1;
                  end
               end
            end
         end
         ST_FILL: begin
            if (fill_pos_ff == nfm_pkg::DIM_AW'(nfm_pkg::DIM - 1)) begin
               if (fill_query_ff) begin
                  state_in     = ST_SEARCH;
                  start_search = 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               fill_pos_in = fill_pos_ff + 1'b1;
            end
         end
         ST_SEARCH: begin
            if (~pipe_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (~rsp_valid_ff || ~rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_beat_in.found         = found_ff;
               rsp_beat_in.best_slot     = nfm_pkg::SLOT_W'(best_entry_ff);
               rsp_beat_in.best_name_id  = best_name_ff;
               rsp_beat_in.best_distance = best_ff;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Search issue: one element address per cycle, entries in ascending order.
   always_comb begin
      issue_in   = issue_ff;
      s_elem_in  = s_elem_ff;
      s_entry_in = s_entry_ff;
      s_addr_in  = s_addr_ff;
      t1_in      = '0;
      if (start_search) begin
         issue_in   = 1'b1;
         s_elem_in  = '0;
         s_entry_in = '0;
         s_addr_in  = '0;
      end else if (issue_ff) begin
         t1_in.act   = 1'b1;
         t1_in.last  = (s_elem_ff == nfm_pkg::DIM_AW'(nfm_pkg::DIM - 1));
         t1_in.hit   = entry_valid_ff[s_entry_ff];
         t1_in.entry = s_entry_ff;
         s_addr_in   = s_addr_ff + 1'b1;
         if (t1_in.last) begin
            s_elem_in = '0;
            if (s_entry_ff == nfm_pkg::ENT_W'(nfm_pkg::ENTRIES - 1)) begin
               issue_in = 1'b0;
            end else begin
               s_entry_in = s_entry_ff + 1'b1;
            end
         end else begin
            s_elem_in = s_elem_ff + 1'b1;
         end
      end
   end

   // Difference, magnitude and square.
   assign diff_wide = {feat_rd_ff[nfm_pkg::ELEM_W-1], feat_rd_ff}
                    - {qry_rd_ff[nfm_pkg::ELEM_W-1], qry_rd_ff};
   assign diff_in   = diff_wide[nfm_pkg::ELEM_W] ? nfm_pkg::ELEM_W'(-diff_wide)
                                                 : diff_wide[nfm_pkg::ELEM_W-1:0];
   assign sq_in     = nfm_pkg::SQ_W'(diff_ff) * nfm_pkg::SQ_W'(diff_ff);
   assign total     = acc_ff + nfm_pkg::ACC_W'(sq_ff);

   // Accumulate and keep the first strict minimum below the threshold.
   always_comb begin
      acc_in        = acc_ff;
      best_in       = best_ff;
      best_entry_in = best_entry_ff;
      best_name_in  = best_name_ff;
      found_in      = found_ff;
      if (start_search) begin
         acc_in        = '0;
         best_in       = threshold_ff;
         best_entry_in = '0;
         best_name_in  = '0;
         found_in      = 1'b0;
      end else if (t3_ff.act) begin
         if (t3_ff.last) begin
            acc_in = '0;
            if (t3_ff.hit &&
                (nfm_pkg::CMP_W'(total) < nfm_pkg::CMP_W'(best_ff))) begin
               best_in       = nfm_pkg::THR_W'(total);
               best_entry_in = t3_ff.entry;
               best_name_in  = name3_ff;
               found_in      = 1'b1;
            end
         end else begin
            acc_in = total;
         end
      end
   end

   // Memories.
   always_ff @(posedge clock) begin
      if (fw_en) begin
         feat_mem[fw_addr] <= fw_data;
      end
      feat_rd_ff <= feat_mem[s_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (qw_en) begin
         qry_mem[qw_addr] <= qw_data;
      end
      qry_rd_ff <= qry_mem[s_elem_ff];
   end

   always_ff @(posedge clock) begin
      if (nw_en) begin
         name_mem[ld_entry] <= req_beat.name_id;
      end
      name_rd_ff <= name_mem[s_entry_ff];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pos_ff         <= '0;
         entry_valid_ff <= '0;
         threshold_ff   <= nfm_pkg::THRESHOLD_RESET;
         issue_ff       <= 1'b0;
         t1_ff          <= '0;
         t2_ff          <= '0;
         t3_ff          <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pos_ff         <= pos_in;
         entry_valid_ff <= entry_valid_in;
         threshold_ff   <= threshold_in;
         issue_ff       <= issue_in;
         t1_ff          <= t1_in;
         t2_ff          <= t1_ff;
         t3_ff          <= t2_ff;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload and datapath registers.
   always_ff @(posedge clock) begin
      fill_pos_ff   <= fill_pos_in;
      fill_query_ff <= fill_query_in;
      fill_entry_ff <= fill_entry_in;
      s_elem_ff     <= s_elem_in;
      s_entry_ff    <= s_entry_in;
      s_addr_ff     <= s_addr_in;
      name2_ff      <= name_rd_ff;
      name3_ff      <= name2_ff;
      diff_ff       <= diff_in;
      sq_ff         <= sq_in;
      acc_ff        <= acc_in;
      best_ff       <= best_in;
      best_entry_ff <= best_entry_in;
      best_name_ff  <= best_name_in;
      found_ff      <= found_in;
      rsp_beat_ff   <= rsp_beat_in;
   end

endmodule
